// ===== sv/i2crm_pkg.sv =====
// Shared types, codes and constants for the I2C register master.
package i2crm_pkg;

	localparam int unsigned COUNT_BITS = 8;
	localparam int unsigned DELAY_BITS = 16;
	localparam int unsigned POLL_BITS  = 8;

	localparam logic [DELAY_BITS-1:0] HALF_RESET    = DELAY_BITS'(5);
	localparam logic [POLL_BITS-1:0]  POLL_RESET    = POLL_BITS'(100);
	localparam logic [3:0]            BITS_PER_BYTE = 4'd8;

	// input beat kinds
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_BEGIN = 2'd1,
		KIND_WDATA = 2'd2
	} kind_t;

	// transaction types
	typedef enum logic [1:0] {
		OP_SCAN  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	// configuration register indexes
	typedef enum logic {
		REG_HALF_PERIOD = 1'b0,
		REG_POLL_LIMIT  = 1'b1
	} cfg_reg_t;

	// bus sequencer phases
	typedef enum logic [4:0] {
		P_IDLE, P_START_SDA, P_START_SCL, P_OUT_SDA, P_OUT_SCLH, P_OUT_SCLL,
		P_RB_SDA, P_RB_SCLH, P_RB_POLL, P_RB_SAMPLE, P_RB_ONE, P_IN_ACKSDA,
		P_IN_SCLH, P_IN_SCLL, P_IN_SDAL, P_WAIT_DATA, P_STOP_PRE, P_STOP_SDA,
		P_STOP_SCL, P_STOP_END
	} phase_t;

	// which byte of the transaction is on the bus
	typedef enum logic [2:0] {
		ST_ADDR_W, ST_REG, ST_ADDR_R, ST_DATA_W, ST_DATA_R, ST_MID
	} stage_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] operation;
		logic [6:0] device_address;
		logic [7:0] register_address;
		logic [COUNT_BITS-1:0] byte_count;
		logic [7:0] write_byte;
		logic       scl_in;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_pull_low;
		logic       sda_pull_low;
		logic [7:0] read_byte;
		logic       read_byte_valid;
		logic       write_byte_request;
		logic       done_res;
		logic       acknowledged;
		logic [COUNT_BITS-1:0] transferred_count;
		logic       busy_res;
	} out_item_t;

	typedef struct packed {
		logic [DELAY_BITS-1:0] half_period_ticks;
		logic [POLL_BITS-1:0]  stretch_poll_limit;
	} cfg_t;

endpackage

// ===== sv/i2c_register_master_core.sv =====
// I2C register master top level: input register, config registers, sequencer, result register.
// Path: an accepted beat is registered in the input register, stepped through the sequencer, and
// its result (ticks only) is loaded into the output register, from which it is offered.
// Throughput: one input beat per clock; the input stalls only while a tick's result cannot
// enter the output register because the held result is stalled.
// Reset (arst_n low): bus drives released, sequencer idle, pipeline empty, half period 5,
// stretch poll limit 100.
module i2c_register_master_core import i2crm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [DELAY_BITS-1:0] cfg_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	cfg_t      cfg_q;
	out_item_t step_res;
	logic      has_res, can_load, advance;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks  <= HALF_RESET;
			cfg_q.stretch_poll_limit <= POLL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HALF_PERIOD: cfg_q.half_period_ticks  <= cfg_data;
				REG_POLL_LIMIT:  cfg_q.stretch_poll_limit <= cfg_data[POLL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// only ticks produce a result beat
	assign has_res  = (item_s1.kind == KIND_TICK);
	assign advance  = valid_s1 && (!has_res || can_load);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	i2crm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (step_res)
	);

	i2crm_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && has_res),
		.load_data(step_res),
		.can_load (can_load),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ===== sv/i2crm_seq.sv =====
// Bus sequencer: holds the transaction state and steps it by one input beat.
module i2crm_seq import i2crm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	phase_t phase_q, phase_n;
	stage_t stage_q, stage_n;
	logic [3:0] bit_q, bit_n;
	logic [7:0] shift_q, shift_n;
	logic [DELAY_BITS-1:0] delay_q, delay_n;
	logic [POLL_BITS-1:0] stretch_q, stretch_n;
	logic [COUNT_BITS-1:0] left_q, left_n, cnt_q, cnt_n;
	logic [6:0] addr_q, addr_n;
	logic [7:0] reg_q, reg_n;
	logic [1:0] op_q, op_n;
	logic scl_q, scl_n, sda_q, sda_n, ack_q, ack_n;
	logic rd_valid, done;
	logic bit_v, ack_bit;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= P_IDLE;
			stage_q   <= ST_ADDR_W;
			bit_q     <= '0;
			shift_q   <= '0;
			delay_q   <= '0;
			stretch_q <= '0;
			left_q    <= '0;
			cnt_q     <= '0;
			addr_q    <= '0;
			reg_q     <= '0;
			op_q      <= '0;
			scl_q     <= 1'b0;
			sda_q     <= 1'b0;
			ack_q     <= 1'b0;
		end else if (step_en) begin
			phase_q   <= phase_n;
			stage_q   <= stage_n;
			bit_q     <= bit_n;
			shift_q   <= shift_n;
			delay_q   <= delay_n;
			stretch_q <= stretch_n;
			left_q    <= left_n;
			cnt_q     <= cnt_n;
			addr_q    <= addr_n;
			reg_q     <= reg_n;
			op_q      <= op_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
			ack_q     <= ack_n;
		end
	end

	// sampled bit for a slave-driven slot; a stretch time-out reads as one
	assign bit_v   = (phase_q == P_RB_SAMPLE) ? item.sda_in : 1'b1;
	assign ack_bit = ~bit_v;

	// next state for one beat
	always_comb begin
		phase_n   = phase_q;
		stage_n   = stage_q;
		bit_n     = bit_q;
		shift_n   = shift_q;
		delay_n   = delay_q;
		stretch_n = stretch_q;
		left_n    = left_q;
		cnt_n     = cnt_q;
		addr_n    = addr_q;
		reg_n     = reg_q;
		op_n      = op_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		ack_n     = ack_q;
		rd_valid  = 1'b0;
		done      = 1'b0;
		case (item.kind)
			KIND_BEGIN: begin
				if (phase_q == P_IDLE && item.operation != 2'd3) begin
					addr_n  = item.device_address;
					reg_n   = item.register_address;
					left_n  = item.byte_count;
					op_n    = item.operation;
					cnt_n   = '0;
					ack_n   = 1'b0;
					delay_n = '0;
					shift_n = {item.device_address, 1'b0};
					bit_n   = '0;
					stage_n = ST_ADDR_W;
					phase_n = P_START_SDA;
				end
			end
			KIND_WDATA: begin
				if (phase_q == P_WAIT_DATA) begin
					shift_n = item.write_byte;
					bit_n   = '0;
					stage_n = ST_DATA_W;
					phase_n = P_OUT_SDA;
				end
			end
			KIND_TICK: begin
				if (delay_q != '0) begin
					delay_n = delay_q - 1'b1;
				end else begin
					case (phase_q)
						P_START_SDA: begin
							sda_n = 1'b1; delay_n = cfg.half_period_ticks; phase_n = P_START_SCL;
						end
						P_START_SCL: begin
							scl_n = 1'b1; bit_n = '0; phase_n = P_OUT_SDA;
						end
						P_OUT_SDA: begin
							sda_n = ~shift_q[7]; phase_n = P_OUT_SCLH;
						end
						P_OUT_SCLH: begin
							scl_n = 1'b0; delay_n = cfg.half_period_ticks; phase_n = P_OUT_SCLL;
						end
						P_OUT_SCLL: begin
							scl_n   = 1'b1;
							shift_n = {shift_q[6:0], 1'b0};
							bit_n   = bit_q + 1'b1;
							delay_n = cfg.half_period_ticks;
							phase_n = (bit_n >= BITS_PER_BYTE) ? P_RB_SDA : P_OUT_SDA;
						end
						P_RB_SDA: begin
							sda_n = 1'b0; delay_n = cfg.half_period_ticks; phase_n = P_RB_SCLH;
						end
						P_RB_SCLH: begin
							scl_n = 1'b0; stretch_n = '0; phase_n = P_RB_POLL;
						end
						P_RB_POLL: begin
							if (item.scl_in) begin
								delay_n = cfg.half_period_ticks; phase_n = P_RB_SAMPLE;
							end else begin
								stretch_n = stretch_q + 1'b1;
								if (stretch_n >= cfg.stretch_poll_limit) begin
									delay_n = cfg.half_period_ticks; phase_n = P_RB_ONE;
								end
							end
						end
						P_RB_SAMPLE, P_RB_ONE: begin
							scl_n = 1'b1;
							case (stage_q)
								ST_DATA_R: begin
									shift_n = {shift_q[6:0], bit_v};
									bit_n   = bit_q + 1'b1;
									phase_n = (bit_n >= BITS_PER_BYTE) ? P_IN_ACKSDA : P_RB_SDA;
								end
								ST_ADDR_W: begin
									ack_n = ack_bit;
									if (op_q == OP_READ) begin
										if (ack_bit) begin
											shift_n = reg_q; bit_n = '0; stage_n = ST_REG;
										end
										delay_n = cfg.half_period_ticks;
										phase_n = ack_bit ? P_OUT_SDA : P_STOP_SDA;
									end else if (op_q == OP_WRITE && ack_bit) begin
										shift_n = reg_q; bit_n = '0; stage_n = ST_REG;
										phase_n = P_OUT_SDA;
									end else begin
										phase_n = P_STOP_SDA;
									end
								end
								ST_REG: begin
									ack_n = ack_q & ack_bit;
									if (op_q == OP_READ) begin
										if (ack_bit) stage_n = ST_MID;
										delay_n = cfg.half_period_ticks;
										phase_n = P_STOP_SDA;
									end else begin
										phase_n = (ack_bit && left_q != '0) ? P_WAIT_DATA
										                                     : P_STOP_SDA;
									end
								end
								ST_ADDR_R: begin
									ack_n   = ack_q & ack_bit;
									delay_n = cfg.half_period_ticks;
									if (ack_bit && left_q != '0) begin
										shift_n = '0; bit_n = '0; stage_n = ST_DATA_R;
										phase_n = P_RB_SDA;
									end else begin
										phase_n = ack_bit ? P_STOP_PRE : P_STOP_SDA;
									end
								end
								ST_DATA_W: begin
									cnt_n   = cnt_q + 1'b1;
									left_n  = left_q - 1'b1;
									phase_n = (ack_bit && left_n != '0) ? P_WAIT_DATA : P_STOP_SDA;
								end
								default: begin
									phase_n = P_STOP_SDA;
								end
							endcase
						end
						P_IN_ACKSDA: begin
							sda_n   = (left_q <= COUNT_BITS'(1)) ? 1'b0 : 1'b1;
							phase_n = P_IN_SCLH;
						end
						P_IN_SCLH: begin
							scl_n = 1'b0; delay_n = cfg.half_period_ticks; phase_n = P_IN_SCLL;
						end
						P_IN_SCLL: begin
							scl_n = 1'b1; delay_n = cfg.half_period_ticks; phase_n = P_IN_SDAL;
						end
						P_IN_SDAL: begin
							sda_n    = 1'b1;
							rd_valid = 1'b1;
							cnt_n    = cnt_q + 1'b1;
							left_n   = left_q - 1'b1;
							if (left_n != '0) begin
								bit_n = '0; phase_n = P_RB_SDA;
							end else begin
								delay_n = cfg.half_period_ticks; phase_n = P_STOP_SDA;
							end
						end
						P_STOP_PRE: begin
							delay_n = cfg.half_period_ticks; phase_n = P_STOP_SDA;
						end
						P_STOP_SDA: begin
							sda_n = 1'b1; delay_n = cfg.half_period_ticks; phase_n = P_STOP_SCL;
						end
						P_STOP_SCL: begin
							scl_n = 1'b0; delay_n = cfg.half_period_ticks; phase_n = P_STOP_END;
						end
						P_STOP_END: begin
							sda_n = 1'b0;
							if (stage_q == ST_MID) begin
								// repeated start with the read address
								shift_n = {addr_q, 1'b1};
								bit_n   = '0;
								stage_n = ST_ADDR_R;
								delay_n = cfg.half_period_ticks;
								phase_n = P_START_SDA;
							end else begin
								done    = 1'b1;
								phase_n = P_IDLE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// result fields from the updated state
	always_comb begin
		result.scl_pull_low       = scl_n;
		result.sda_pull_low       = sda_n;
		result.read_byte          = rd_valid ? shift_n : 8'd0;
		result.read_byte_valid    = rd_valid;
		result.write_byte_request = (phase_n == P_WAIT_DATA);
		result.done_res           = done;
		result.acknowledged       = done & ack_n;
		result.transferred_count  = done ? cnt_n : '0;
		result.busy_res           = (phase_n != P_IDLE);
	end

endmodule

// ===== sv/i2crm_out_reg.sv =====
// Result register with valid/stall handshake toward the consumer.
module i2crm_out_reg import i2crm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t load_data,
	output logic      can_load,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic      valid_q;
	out_item_t data_q;

	// free when empty or when the held beat leaves this edge
	assign can_load  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the I2C register master core with a line-level bus predictor.
`timescale 1ns / 100ps

module testbench;
	import i2crm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned PHASE_TICKS = 340;

	logic      clk;
	logic      arst_n;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = 1'b0;
	logic [DELAY_BITS-1:0] cfg_data = '0;

	i2c_register_master_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bus sequencer mirror
	phase_t      seq_phase;
	stage_t      cur_byte;
	op_t         cur_op;
	logic [3:0]  bit_cnt;
	logic [7:0]  shreg;
	logic [DELAY_BITS-1:0] wait_cnt;
	logic [7:0]  poll_cnt;
	logic [COUNT_BITS-1:0] bytes_left;
	logic [COUNT_BITS-1:0] bytes_moved;
	logic [6:0]  dev_addr;
	logic [7:0]  reg_addr;
	logic        scl_low;
	logic        sda_low;
	logic        ack_ok;
	logic [DELAY_BITS-1:0] half_ticks;
	logic [7:0]  poll_limit;

	out_item_t   pending_results[$];

	// slave behavior and traffic shaping
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int nack_pct      = 0;
	int nack_at       = -1;
	int acks_seen     = 0;
	int stretch_pct   = 0;
	int noise_pct     = 0;
	bit extreme_data  = 1'b0;

	int unsigned cycle_count     = 0;
	int unsigned ticks_sent      = 0;
	int unsigned transfers_run   = 0;
	int unsigned results_checked = 0;
	int unsigned bytes_read      = 0;
	int unsigned mismatches      = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d results still due", $time, cycle_count,
				pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_sequencer();
		seq_phase   = P_IDLE;
		cur_byte    = ST_ADDR_W;
		cur_op      = OP_SCAN;
		bit_cnt     = '0;
		shreg       = '0;
		wait_cnt    = '0;
		poll_cnt    = '0;
		bytes_left  = '0;
		bytes_moved = '0;
		dev_addr    = '0;
		reg_addr    = '0;
		scl_low     = 1'b0;
		sda_low     = 1'b0;
		ack_ok      = 1'b0;
		half_ticks  = HALF_RESET;
		poll_limit  = POLL_RESET;
	endfunction

	function automatic void arm_wait(phase_t nxt);
		wait_cnt  = half_ticks;
		seq_phase = nxt;
	endfunction

	function automatic void load_shift(logic [7:0] value, stage_t which);
		shreg    = value;
		bit_cnt  = '0;
		cur_byte = which;
	endfunction

	// slave answer to an outgoing byte
	function automatic void byte_acked(logic ack);
		case (cur_byte)
			ST_ADDR_W: begin
				ack_ok = ack;
				if (cur_op == OP_READ) begin
					if (ack)
						load_shift(reg_addr, ST_REG);
					arm_wait(ack ? P_OUT_SDA : P_STOP_SDA);
				end else if (cur_op == OP_WRITE && ack) begin
					load_shift(reg_addr, ST_REG);
					seq_phase = P_OUT_SDA;
				end else begin
					seq_phase = P_STOP_SDA;
				end
			end
			ST_REG: begin
				ack_ok &= ack;
				if (cur_op == OP_READ) begin
					if (ack)
						cur_byte = ST_MID;
					arm_wait(P_STOP_SDA);
				end else begin
					seq_phase = (ack && bytes_left != 0) ? P_WAIT_DATA : P_STOP_SDA;
				end
			end
			ST_ADDR_R: begin
				ack_ok &= ack;
				if (ack && bytes_left != 0) begin
					load_shift(8'h00, ST_DATA_R);
					arm_wait(P_RB_SDA);
				end else begin
					arm_wait(ack ? P_STOP_PRE : P_STOP_SDA);
				end
			end
			ST_DATA_W: begin
				bytes_moved++;
				bytes_left--;
				seq_phase = (ack && bytes_left != 0) ? P_WAIT_DATA : P_STOP_SDA;
			end
			default: seq_phase = P_STOP_SDA;
		endcase
	endfunction

	function automatic void bit_sampled(logic v);
		scl_low = 1'b1;
		if (cur_byte == ST_DATA_R) begin
			shreg = {shreg[6:0], v};
			bit_cnt++;
			seq_phase = (bit_cnt >= BITS_PER_BYTE) ? P_IN_ACKSDA : P_RB_SDA;
		end else begin
			byte_acked(!v);
		end
	endfunction

	// one accepted beat; only ticks produce a result
	function automatic void bus_step(input in_item_t it, output logic emit, output out_item_t r);
		logic rd_new;
		logic fin;
		rd_new = 1'b0;
		fin    = 1'b0;
		emit   = 1'b0;
		r      = '0;
		if (it.kind == KIND_BEGIN) begin
			if (seq_phase == P_IDLE && it.operation <= OP_WRITE) begin
				dev_addr    = it.device_address;
				reg_addr    = it.register_address;
				bytes_left  = it.byte_count;
				cur_op      = op_t'(it.operation);
				bytes_moved = '0;
				ack_ok      = 1'b0;
				wait_cnt    = '0;
				load_shift({it.device_address, 1'b0}, ST_ADDR_W);
				seq_phase = P_START_SDA;
			end
			return;
		end
		if (it.kind == KIND_WDATA) begin
			if (seq_phase == P_WAIT_DATA) begin
				load_shift(it.write_byte, ST_DATA_W);
				seq_phase = P_OUT_SDA;
			end
			return;
		end
		if (it.kind != KIND_TICK)
			return;

		if (wait_cnt != 0) begin
			wait_cnt--;
		end else begin
			case (seq_phase)
				P_START_SDA: begin
					sda_low = 1'b1;
					arm_wait(P_START_SCL);
				end
				P_START_SCL: begin
					scl_low   = 1'b1;
					bit_cnt   = '0;
					seq_phase = P_OUT_SDA;
				end
				P_OUT_SDA: begin
					sda_low   = !shreg[7];
					seq_phase = P_OUT_SCLH;
				end
				P_OUT_SCLH: begin
					scl_low = 1'b0;
					arm_wait(P_OUT_SCLL);
				end
				P_OUT_SCLL: begin
					scl_low = 1'b1;
					shreg   = {shreg[6:0], 1'b0};
					bit_cnt++;
					arm_wait(bit_cnt >= BITS_PER_BYTE ? P_RB_SDA : P_OUT_SDA);
				end
				P_RB_SDA: begin
					sda_low = 1'b0;
					arm_wait(P_RB_SCLH);
				end
				P_RB_SCLH: begin
					scl_low   = 1'b0;
					poll_cnt  = '0;
					seq_phase = P_RB_POLL;
				end
				P_RB_POLL: begin
					if (it.scl_in) begin
						arm_wait(P_RB_SAMPLE);
					end else begin
						poll_cnt++;
						if (poll_cnt >= poll_limit)
							arm_wait(P_RB_ONE);
					end
				end
				P_RB_SAMPLE: bit_sampled(it.sda_in);
				P_RB_ONE:    bit_sampled(1'b1);
				P_IN_ACKSDA: begin
					// NACK the last byte of a read
					sda_low   = (bytes_left <= 1) ? 1'b0 : 1'b1;
					seq_phase = P_IN_SCLH;
				end
				P_IN_SCLH: begin
					scl_low = 1'b0;
					arm_wait(P_IN_SCLL);
				end
				P_IN_SCLL: begin
					scl_low = 1'b1;
					arm_wait(P_IN_SDAL);
				end
				P_IN_SDAL: begin
					sda_low = 1'b1;
					rd_new  = 1'b1;
					bytes_moved++;
					bytes_left--;
					if (bytes_left != 0) begin
						bit_cnt   = '0;
						seq_phase = P_RB_SDA;
					end else begin
						arm_wait(P_STOP_SDA);
					end
				end
				P_STOP_PRE: arm_wait(P_STOP_SDA);
				P_STOP_SDA: begin
					sda_low = 1'b1;
					arm_wait(P_STOP_SCL);
				end
				P_STOP_SCL: begin
					scl_low = 1'b0;
					arm_wait(P_STOP_END);
				end
				P_STOP_END: begin
					sda_low = 1'b0;
					// a register read restarts with the read address
					if (cur_byte == ST_MID) begin
						load_shift({dev_addr, 1'b1}, ST_ADDR_R);
						arm_wait(P_START_SDA);
					end else begin
						fin       = 1'b1;
						seq_phase = P_IDLE;
					end
				end
				default: ;
			endcase
		end

		emit                 = 1'b1;
		r.scl_pull_low       = scl_low;
		r.sda_pull_low       = sda_low;
		r.read_byte          = rd_new ? shreg : 8'h00;
		r.read_byte_valid    = rd_new;
		r.write_byte_request = (seq_phase == P_WAIT_DATA);
		r.done_res           = fin;
		r.acknowledged       = fin ? ack_ok : 1'b0;
		r.transferred_count  = fin ? bytes_moved : '0;
		r.busy_res           = (seq_phase != P_IDLE);
	endfunction

	// predict on every accepted input beat
	always @(posedge clk) begin
		logic      emit;
		out_item_t r;
		if (arst_n && in_valid && !in_stall) begin
			bus_step(in_data, emit, r);
			if (emit)
				pending_results.push_back(r);
		end
	end

	// ---------------------------------------------------------------- result check

	function automatic void field_err(string name, logic [7:0] want, logic [7:0] got);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want, got);
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result beat: expected none, got %h", $time, out_data);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (out_data.read_byte_valid === 1'b1)
					bytes_read++;
				if (out_data.scl_pull_low !== want.scl_pull_low)
					field_err("scl_pull_low", want.scl_pull_low, out_data.scl_pull_low);
				if (out_data.sda_pull_low !== want.sda_pull_low)
					field_err("sda_pull_low", want.sda_pull_low, out_data.sda_pull_low);
				if (out_data.read_byte !== want.read_byte)
					field_err("read_byte", want.read_byte, out_data.read_byte);
				if (out_data.read_byte_valid !== want.read_byte_valid)
					field_err("read_byte_valid", want.read_byte_valid, out_data.read_byte_valid);
				if (out_data.write_byte_request !== want.write_byte_request)
					field_err("write_byte_request", want.write_byte_request,
						out_data.write_byte_request);
				if (out_data.done_res !== want.done_res)
					field_err("done_res", want.done_res, out_data.done_res);
				if (out_data.acknowledged !== want.acknowledged)
					field_err("acknowledged", want.acknowledged, out_data.acknowledged);
				if (out_data.transferred_count !== want.transferred_count)
					field_err("transferred_count", want.transferred_count,
						out_data.transferred_count);
				if (out_data.busy_res !== want.busy_res)
					field_err("busy_res", want.busy_res, out_data.busy_res);
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
	end

	// ---------------------------------------------------------------- stimulus

	// send one beat; valid stays high until the next beat or a hold-off
	task automatic push_beat(input in_item_t it);
		int gap;
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		if (it.kind == KIND_TICK)
			ticks_sent++;
	endtask

	// stop sending and let every expected result arrive
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [DELAY_BITS-1:0] value);
		wait_quiet();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_HALF_PERIOD)
			half_ticks = value;
		else
			poll_limit = value[7:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t random_fields();
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		return rnd[$bits(in_item_t)-1:0];
	endfunction

	// tick carrying line levels from a slave that stretches and ACKs as told
	function automatic in_item_t line_tick();
		in_item_t it;
		it      = random_fields();
		it.kind = KIND_TICK;
		if (seq_phase == P_RB_POLL && wait_cnt == 0)
			it.scl_in = ($urandom_range(0, 99) >= stretch_pct);
		else
			it.scl_in = ($urandom_range(0, 19) == 0) ? scl_low : !scl_low;
		if (seq_phase == P_RB_SAMPLE && wait_cnt == 0) begin
			if (cur_byte == ST_DATA_R) begin
				it.sda_in = $urandom_range(0, 1);
			end else begin
				it.sda_in = (acks_seen == nack_at) || ($urandom_range(0, 99) < nack_pct);
				acks_seen++;
			end
		end else begin
			it.sda_in = sda_low ? 1'b0 : 1'($urandom_range(0, 1));
		end
		return it;
	endfunction

	function automatic in_item_t data_beat();
		in_item_t it;
		it            = random_fields();
		it.kind       = KIND_WDATA;
		it.write_byte = extreme_data ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
		return it;
	endfunction

	// beats the block should drop: odd kind, unknown operation, stray data, begin while busy
	function automatic in_item_t stray_beat();
		in_item_t it;
		it = random_fields();
		case ($urandom_range(0, 2))
			0: it.kind = 2'd3;
			1: it.kind = KIND_WDATA;
			default: begin
				it.kind = KIND_BEGIN;
				if (seq_phase == P_IDLE)
					it.operation = 2'd3;
			end
		endcase
		return it;
	endfunction

	task automatic set_bus(int nack_bit, int stretch);
		nack_at     = nack_bit;
		nack_pct    = 0;
		stretch_pct = stretch;
	endtask

	task automatic start_transfer(op_t op, logic [6:0] dev, logic [7:0] regno,
			logic [COUNT_BITS-1:0] count);
		in_item_t it;
		it                  = random_fields();
		it.kind             = KIND_BEGIN;
		it.operation        = op;
		it.device_address   = dev;
		it.register_address = regno;
		it.byte_count       = count;
		acks_seen           = 0;
		transfers_run++;
		push_beat(it);
	endtask

	// tick the bus until the stop, feeding data when asked
	task automatic finish_transfer();
		while (seq_phase != P_IDLE) begin
			if (seq_phase == P_WAIT_DATA && $urandom_range(0, 3) != 0)
				push_beat(data_beat());
			else if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
				push_beat(stray_beat());
			else
				push_beat(line_tick());
		end
	endtask

	task automatic run_transfer(op_t op, logic [6:0] dev, logic [7:0] regno,
			logic [COUNT_BITS-1:0] count);
		start_transfer(op, dev, regno, count);
		finish_transfer();
	endtask

	task automatic idle_ticks(int n);
		repeat (n) push_beat(line_tick());
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_scan();
		set_bus(-1, 0);
		idle_ticks(3);
		run_transfer(OP_SCAN, 7'h7F, 8'hFF, 8'hFF);
		set_bus(0, 0);
		run_transfer(OP_SCAN, 7'h00, 8'h00, 8'h00);
		wait_quiet();
	endtask

	task automatic test_register_write();
		write_cfg(REG_HALF_PERIOD, 16'd1);
		extreme_data = 1'b1;
		set_bus(-1, 0);
		run_transfer(OP_WRITE, 7'h55, 8'hFF, 8'd3);
		run_transfer(OP_WRITE, 7'h2A, 8'h00, 8'd0);
		// data NACK on the second data byte ends the write early
		set_bus(3, 0);
		run_transfer(OP_WRITE, 7'h11, 8'h80, 8'd4);
		set_bus(0, 0);
		run_transfer(OP_WRITE, 7'h22, 8'h01, 8'd2);
		set_bus(1, 0);
		run_transfer(OP_WRITE, 7'h33, 8'hFE, 8'd2);
		extreme_data = 1'b0;
	endtask

	task automatic test_register_read();
		set_bus(-1, 0);
		run_transfer(OP_READ, 7'h50, 8'h10, 8'd2);
		run_transfer(OP_READ, 7'h7F, 8'hFF, 8'd0);
		run_transfer(OP_READ, 7'h01, 8'h20, 8'd1);
		set_bus(0, 0);
		run_transfer(OP_READ, 7'h02, 8'h30, 8'd2);
		set_bus(1, 0);
		run_transfer(OP_READ, 7'h03, 8'h40, 8'd2);
		// read address NACKed after the restart
		set_bus(2, 0);
		run_transfer(OP_READ, 7'h04, 8'h50, 8'd2);
		wait_quiet();
	endtask

	task automatic test_clock_stretch();
		// slave never releases SCL: every bit times out as one
		write_cfg(REG_POLL_LIMIT, {8'($urandom), 8'd1});
		set_bus(-1, 100);
		run_transfer(OP_SCAN, 7'h40, 8'h00, 8'd0);
		write_cfg(REG_POLL_LIMIT, {8'($urandom), 8'd0});
		set_bus(-1, 50);
		run_transfer(OP_READ, 7'h41, 8'h01, 8'd1);
		write_cfg(REG_POLL_LIMIT, 16'd255);
		set_bus(-1, 90);
		run_transfer(OP_WRITE, 7'h42, 8'h02, 8'd1);
		set_bus(-1, 0);
		write_cfg(REG_POLL_LIMIT, 16'd100);
	endtask

	task automatic test_ignored_beats();
		repeat (6) push_beat(stray_beat());
		idle_ticks(2);
		noise_pct = 30;
		run_transfer(OP_WRITE, 7'h60, 8'h61, 8'd2);
		run_transfer(OP_READ, 7'h62, 8'h63, 8'd1);
		noise_pct = 0;
	endtask

	task automatic test_half_period_zero();
		write_cfg(REG_HALF_PERIOD, 16'd0);
		set_bus(-1, 0);
		run_transfer(OP_READ, 7'h0F, 8'hA5, 8'd3);
		run_transfer(OP_WRITE, 7'h70, 8'h5A, 8'd2);
	endtask

	task automatic test_full_counts();
		set_bus(-1, 0);
		run_transfer(OP_READ, 7'h00, 8'h00, 8'd255);
		extreme_data = 1'b1;
		run_transfer(OP_WRITE, 7'h7F, 8'hFF, 8'd255);
		extreme_data = 1'b0;
	endtask

	// longest half period: ride out one full delay, then finish quickly
	task automatic test_long_half_period();
		write_cfg(REG_HALF_PERIOD, 16'hFFFF);
		set_bus(-1, 0);
		start_transfer(OP_SCAN, 7'h2A, 8'h00, 8'd0);
		while (seq_phase != P_OUT_SDA)
			push_beat(line_tick());
		write_cfg(REG_HALF_PERIOD, 16'd1);
		finish_transfer();
	endtask

	task automatic random_phase(int idle_pct, int stall, logic [15:0] half, logic [7:0] poll);
		int unsigned tick_goal;
		op_t         op;
		logic [6:0]  dev;
		logic [COUNT_BITS-1:0] count;
		write_cfg(REG_HALF_PERIOD, half);
		write_cfg(REG_POLL_LIMIT, {8'($urandom), poll});
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		noise_pct     = 6;
		tick_goal     = ticks_sent + PHASE_TICKS;
		while (ticks_sent < tick_goal) begin
			op    = op_t'($urandom_range(0, 2));
			dev   = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 7'h7F : 7'h00)
				: 7'($urandom);
			count = ($urandom_range(0, 9) == 0) ? COUNT_BITS'($urandom_range(4, 8))
				: COUNT_BITS'($urandom_range(0, 3));
			nack_at     = $urandom_range(0, 2) == 0 ? int'($urandom_range(0, 3)) : -1;
			nack_pct    = $urandom_range(0, 1) ? 0 : ($urandom_range(0, 1) ? 5 : 30);
			stretch_pct = $urandom_range(0, 1) ? 0 : ($urandom_range(0, 1) ? 30 : 80);
			run_transfer(op, dev, 8'($urandom), count);
			idle_ticks($urandom_range(0, 3));
		end
		noise_pct = 0;
		wait_quiet();
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	task automatic test_random_traffic();
		random_phase(0, 0, 16'd1, 8'd100);
		random_phase(54, 0, 16'd0, 8'd1);
		random_phase(0, 54, 16'd2, 8'd255);
		random_phase(22, 22, 16'd1, 8'd0);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		clear_sequencer();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_scan();
		test_register_write();
		test_register_read();
		test_clock_stretch();
		test_ignored_beats();
		test_half_period_zero();
		test_full_counts();
		test_long_half_period();
		test_random_traffic();

		wait_quiet();
		repeat (10) @(posedge clk);
		$display("Ran %0d transactions (scan, register read/write, NACKs, stretching, stray beats)",
			transfers_run);
		$display("over %0d ticks: %0d results checked, %0d bytes read, %0d mismatches",
			ticks_sent, results_checked, bytes_read, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/i2crm_pkg.sv
sv/i2crm_seq.sv
sv/i2crm_out_reg.sv
sv/i2c_register_master_core.sv
sim/testbench.sv
